// ===== hw/rtl/checksummed_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// checksummed frame receiver assertion macros
// concurrent checks on the clock, masked while reset is low, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH
`define CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CFR_ASSERT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CFR_ASSERT(name, clk, rst_n, ante, cons, msg)
`define CFR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// shared constants, status codes and types of the checksummed frame receiver
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned MaxPayload = 48;

  localparam logic [7:0] StartByte = 8'h3A;
  localparam logic [7:0] CrByte    = 8'h0D;
  localparam logic [7:0] LfByte    = 8'h0A;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StWrongId    = 3'd1,
    StBadCmd     = 3'd2,
    StBadTrailer = 3'd3,
    StChecksum   = 3'd4,
    StNoStart    = 3'd5,
    StTooLong    = 3'd6
  } status_e;

  // parser events toward the output side
  typedef struct packed {
    logic    res_valid;    // one status item (no payload)
    status_e res_status;
    logic    drain_start;  // good frame with payload, release buffer
  } parse_evt_t;

  // fixed set of accepted command words
  function automatic logic cmd_known(logic [15:0] cmd);
    logic known;
    case (cmd)
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7,
      16'd9, 16'd10, 16'd11, 16'd20, 16'd21, 16'd25, 16'd26, 16'd31,
      16'd32, 16'd33, 16'd34, 16'd41, 16'd42, 16'd43, 16'd44, 16'd60,
      16'd61, 16'd66, 16'd67, 16'd68, 16'd75, 16'd84, 16'd85, 16'd86: begin
        known = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    return known;
  endfunction

endpackage

// ===== hw/rtl/cfr_buf.sv =====
// ----------------------------------------------------------------------------
// cfr_buf
// payload buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module cfr_buf #(
  parameter int unsigned MAX_PAYLOAD = cfr_pkg::MaxPayload,
  parameter int unsigned AW          = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cfr_parser.sv =====
// ----------------------------------------------------------------------------
// cfr_parser
// byte-level frame state machine, header capture, running checksum
// ----------------------------------------------------------------------------
module cfr_parser #(
  parameter int unsigned MAX_PAYLOAD = cfr_pkg::MaxPayload,
  parameter int unsigned AW          = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  input  logic [15:0]         device_id_i,
  output cfr_pkg::parse_evt_t evt_o,
  output logic [15:0]         cmd_o,
  output logic [15:0]         len_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_addr_o,
  output logic [7:0]          mem_wdata_o
);

  localparam int unsigned CW     = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  typedef enum logic [12:0] {
    PhIdle    = 13'b0000000000001,
    PhIdLo    = 13'b0000000000010,
    PhIdHi    = 13'b0000000000100,
    PhCmdLo   = 13'b0000000001000,
    PhCmdHi   = 13'b0000000010000,
    PhLenLo   = 13'b0000000100000,
    PhLenHi   = 13'b0000001000000,
    PhPayload = 13'b0000010000000,
    PhSumLo   = 13'b0000100000000,
    PhSumHi   = 13'b0001000000000,
    PhCr      = 13'b0010000000000,
    PhLf      = 13'b0100000000000,
    PhHunt    = 13'b1000000000000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [7:0]    low_q, low_d;
  logic [15:0]   id_q, id_d;
  logic [15:0]   cmd_q, cmd_d;
  logic [15:0]   len_q, len_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] cnt_inc;
  logic [15:0]   sum_q, sum_d;
  logic [15:0]   rsum_q, rsum_d;
  logic          prev_cr_q, prev_cr_d;
  logic [15:0]   word;

  assign word    = {byte_i, low_q};
  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    low_d     = low_q;
    id_d      = id_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    rsum_d    = rsum_q;
    prev_cr_d = prev_cr_q;
    evt_o     = '{res_valid: 1'b0, res_status: cfr_pkg::StOk, drain_start: 1'b0};
    mem_we_o  = 1'b0;

    if (byte_valid_i) begin
      case (phase_q)
        PhIdle: begin
          cmd_d = '0;
          len_d = '0;
          if (byte_i == cfr_pkg::StartByte) begin
            phase_d = PhIdLo;
          end else begin
            evt_o.res_valid  = 1'b1;
            evt_o.res_status = cfr_pkg::StNoStart;
            phase_d          = PhHunt;
            prev_cr_d        = 1'b0;
          end
        end
        PhIdLo: begin
          low_d   = byte_i;
          phase_d = PhIdHi;
        end
        PhIdHi: begin
          id_d    = word;
          phase_d = PhCmdLo;
        end
        PhCmdLo: begin
          low_d   = byte_i;
          phase_d = PhCmdHi;
        end
        PhCmdHi: begin
          cmd_d   = word;
          phase_d = PhLenLo;
        end
        PhLenLo: begin
          low_d   = byte_i;
          phase_d = PhLenHi;
        end
        PhLenHi: begin
          len_d = word;
          // id first, then command, then length bound
          if (id_q != device_id_i) begin
            evt_o.res_valid  = 1'b1;
            evt_o.res_status = cfr_pkg::StWrongId;
            phase_d          = PhIdle;
          end else if (!cfr_pkg::cmd_known(cmd_q)) begin
            evt_o.res_valid  = 1'b1;
            evt_o.res_status = cfr_pkg::StBadCmd;
            phase_d          = PhIdle;
          end else if (word > MaxLen) begin
            evt_o.res_valid  = 1'b1;
            evt_o.res_status = cfr_pkg::StTooLong;
            phase_d          = PhHunt;
            prev_cr_d        = 1'b0;
          end else begin
            sum_d   = device_id_i + cmd_q + word;
            cnt_d   = '0;
            phase_d = (word == 16'd0) ? PhSumLo : PhPayload;
          end
        end
        PhPayload: begin
          mem_we_o = 1'b1;
          sum_d    = sum_q + {8'd0, byte_i};
          cnt_d    = cnt_inc;
          if (16'(cnt_inc) >= len_q) begin
            phase_d = PhSumLo;
          end
        end
        PhSumLo: begin
          low_d   = byte_i;
          phase_d = PhSumHi;
        end
        PhSumHi: begin
          rsum_d  = word;
          phase_d = PhCr;
        end
        PhCr: begin
          prev_cr_d = (byte_i == cfr_pkg::CrByte);
          phase_d   = PhLf;
        end
        PhLf: begin
          if (!(prev_cr_q && byte_i == cfr_pkg::LfByte)) begin
            evt_o.res_valid  = 1'b1;
            evt_o.res_status = cfr_pkg::StBadTrailer;
            phase_d          = PhHunt;
            prev_cr_d        = 1'b0;
          end else if (rsum_q != sum_q) begin
            evt_o.res_valid  = 1'b1;
            evt_o.res_status = cfr_pkg::StChecksum;
            phase_d          = PhIdle;
          end else begin
            phase_d = PhIdle;
            if (len_q == 16'd0) begin
              evt_o.res_valid = 1'b1;
            end else begin
              evt_o.drain_start = 1'b1;
            end
          end
        end
        PhHunt: begin
          if (prev_cr_q && byte_i == cfr_pkg::LfByte) begin
            phase_d   = PhIdle;
            prev_cr_d = 1'b0;
          end else begin
            prev_cr_d = (byte_i == cfr_pkg::CrByte);
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      low_q     <= '0;
      id_q      <= '0;
      cmd_q     <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      sum_q     <= '0;
      rsum_q    <= '0;
      prev_cr_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      low_q     <= low_d;
      id_q      <= id_d;
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      sum_q     <= sum_d;
      rsum_q    <= rsum_d;
      prev_cr_q <= prev_cr_d;
    end
  end

  // header words as they stand after this byte
  assign cmd_o       = cmd_d;
  assign len_o       = len_d;
  assign mem_addr_o  = cnt_q[AW-1:0];
  assign mem_wdata_o = byte_i;

endmodule

// ===== hw/rtl/checksummed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// parses 0x3A-framed, sum16-checked serial frames and releases payload items
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata[7:0] rx_byte
//   m_axis    out  tvalid/tready          tdata data/command/length,
//                                         tuser has_data/status, tlast
//   cfg       in   cfg_we_i (no wait)     cfg_wdata_i device_id
//
// - one received byte is taken per cycle while tready is high
// - a good frame's payload drains from the buffer byte by byte, each byte a
//   buffer read followed by a load of the output register, and a new read waits
//   for the output register to be free; no byte is taken during the drain
// - a status item is held in the output register, a second one in a skid
//   slot; input also stalls while that slot is full
// - asynchronous active-low reset; device_id resets to 1, buffer has no reset
//   and needs no clearing pass
// ----------------------------------------------------------------------------
`include "checksummed_frame_receiver_assert.svh"

module checksummed_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = cfr_pkg::MaxPayload
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] data_byte, [23:8] command, [39:24] length
  output logic [3:0]  m_axis_tuser,   // [0] has_data, [3:1] status
  output logic        m_axis_tlast
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

  // configuration register
  logic [15:0] device_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= 16'd1;
    end else if (cfg_we_i) begin
      device_id_q <= cfg_wdata_i;
    end
  end

  // parser and buffer
  cfr_pkg::parse_evt_t evt;
  logic                in_acc;
  logic [15:0]         frame_cmd;
  logic [15:0]         frame_len;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;
  logic                rd_issue;
  logic [7:0]          mem_rdata;

  // drain sequencer
  logic                drain_q, drain_d;
  logic [CW-1:0]       drain_idx_q, drain_idx_d;
  logic [CW-1:0]       drain_idx_inc;
  logic                rd_pend_q;
  logic                rd_last_q, rd_last_d;

  // output register and skid slot
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_data_q, out_data_d;
  logic                out_has_q, out_has_d;
  logic                out_last_q, out_last_d;
  cfr_pkg::status_e    out_status_q, out_status_d;
  logic [15:0]         out_cmd_q, out_cmd_d;
  logic [15:0]         out_len_q, out_len_d;
  logic                skid_q, skid_d;
  cfr_pkg::status_e    skid_status_q, skid_status_d;
  logic [15:0]         skid_cmd_q, skid_cmd_d;
  logic [15:0]         skid_len_q, skid_len_d;
  logic                out_free;

  assign s_axis_tready = !drain_q && !rd_pend_q && !skid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  cfr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(in_acc),
    .byte_i      (s_axis_tdata),
    .device_id_i (device_id_q),
    .evt_o       (evt),
    .cmd_o       (frame_cmd),
    .len_o       (frame_len),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  cfr_buf #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (rd_issue),
    .raddr_i(drain_idx_q[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  // one buffer read in flight at a time, issued only when the output
  // register will be free on the cycle the data lands
  assign rd_issue      = drain_q && !rd_pend_q && out_free;
  assign drain_idx_inc = drain_idx_q + 1'b1;

  always_comb begin
    drain_d     = drain_q;
    drain_idx_d = drain_idx_q;
    rd_last_d   = rd_last_q;
    if (in_acc && evt.drain_start) begin
      drain_d     = 1'b1;
      drain_idx_d = '0;
    end else if (rd_issue) begin
      drain_idx_d = drain_idx_inc;
      rd_last_d   = (16'(drain_idx_inc) == frame_len);
      if (16'(drain_idx_inc) == frame_len) begin
        drain_d = 1'b0;
      end
    end
  end

  // output register loading: buffer data, then skid, then a new status item
  always_comb begin
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;
    out_has_d     = out_has_q;
    out_last_d    = out_last_q;
    out_status_d  = out_status_q;
    out_cmd_d     = out_cmd_q;
    out_len_d     = out_len_q;
    skid_d        = skid_q;
    skid_status_d = skid_status_q;
    skid_cmd_d    = skid_cmd_q;
    skid_len_d    = skid_len_q;

    if (rd_pend_q) begin
      out_valid_d  = 1'b1;
      out_data_d   = mem_rdata;
      out_has_d    = 1'b1;
      out_last_d   = rd_last_q;
      out_status_d = cfr_pkg::StOk;
      out_cmd_d    = frame_cmd;
      out_len_d    = frame_len;
    end else if (skid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_data_d   = '0;
      out_has_d    = 1'b0;
      out_last_d   = 1'b1;
      out_status_d = skid_status_q;
      out_cmd_d    = skid_cmd_q;
      out_len_d    = skid_len_q;
      skid_d       = 1'b0;
    end else if (in_acc && evt.res_valid) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_data_d   = '0;
        out_has_d    = 1'b0;
        out_last_d   = 1'b1;
        out_status_d = evt.res_status;
        out_cmd_d    = frame_cmd;
        out_len_d    = frame_len;
      end else begin
        skid_d        = 1'b1;
        skid_status_d = evt.res_status;
        skid_cmd_d    = frame_cmd;
        skid_len_d    = frame_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q     <= 1'b0;
      drain_idx_q <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else begin
      drain_q     <= drain_d;
      drain_idx_q <= drain_idx_d;
      rd_pend_q   <= rd_issue;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
      skid_q      <= skid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_data_q    <= out_data_d;
    out_has_q     <= out_has_d;
    out_last_q    <= out_last_d;
    out_status_q  <= out_status_d;
    out_cmd_q     <= out_cmd_d;
    out_len_q     <= out_len_d;
    skid_status_q <= skid_status_d;
    skid_cmd_q    <= skid_cmd_d;
    skid_len_q    <= skid_len_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_len_q, out_cmd_q, out_data_q};
  assign m_axis_tuser  = {out_status_q, out_has_q};
  assign m_axis_tlast  = out_last_q;

  // buffer data always lands in an empty output register
  `CFR_ASSERT(a_rd_into_free, clk_i, rst_ni, rd_pend_q, !out_valid_q,
              "buffer read collides with held item")
  // a held status item never overlaps a payload drain
  `CFR_ASSERT(a_skid_no_drain, clk_i, rst_ni, skid_q, !drain_q && !rd_pend_q,
              "skid slot full during drain")
  // buffer is never written while it is being read out
  `CFR_ASSERT(a_no_wr_in_drain, clk_i, rst_ni, mem_we, !drain_q && !rd_pend_q,
              "buffer write during drain")
  // a good frame with payload starts the drain at the first entry
  `CFR_ASSERT_NEXT(a_drain_start, clk_i, rst_ni, in_acc && evt.drain_start,
                   drain_q && drain_idx_q == '0, "drain did not start")

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the checksummed frame receiver: a queue-fed byte
// driver and a result monitor, both clocked, with a byte-level predictor that
// tracks the parser state and queues the items each accepted byte releases
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod    = 12;
  localparam int SettleCycles = 2 * int'(cfr_pkg::MaxPayload) + 16;  // longest drain plus margin
  localparam int LongHold     = 400;                  // receiver hold-off in cycles
  localparam int CycleLimit   = 1000000;

  typedef enum logic [2:0] {
    RxIdle, RxHeader, RxPayload, RxSumLo, RxSumHi, RxCr, RxLf, RxHunt
  } rx_phase_e;

  typedef enum logic [1:0] {FrGood, FrBadSum, FrBadCr, FrBadLf} frame_fault_e;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             has_data;
    logic             is_last;
    cfr_pkg::status_e status;
    logic [15:0]      command;
    logic [15:0]      length;
  } rx_result_t;

  // dut signals; the inputs are known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;   // [7:0] data_byte, [23:8] command, [39:24] length
  logic [3:0]  m_axis_tuser;   // [0] has_data, [3:1] status
  logic        m_axis_tlast;

  checksummed_frame_receiver #(
    .MAX_PAYLOAD(cfr_pkg::MaxPayload)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // stimulus and scoreboard state
  logic [7:0]  rx_bytes_q[$];
  rx_result_t  expected_results_q[$];
  int unsigned bytes_queued   = 0;
  int unsigned bytes_accepted = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  bit          idle_en        = 1'b1;
  int unsigned hold_req       = 0;
  int unsigned hold_ack       = 0;
  int          send_gap       = 0;
  int          recv_wait      = 0;
  int          hold_left      = 0;
  logic [15:0] cfg_device_id  = 16'd1;
  rx_result_t  want;

  logic [15:0] listed_cmds [32] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7,
    16'd9, 16'd10, 16'd11, 16'd20, 16'd21, 16'd25, 16'd26, 16'd31,
    16'd32, 16'd33, 16'd34, 16'd41, 16'd42, 16'd43, 16'd44, 16'd60,
    16'd61, 16'd66, 16'd67, 16'd68, 16'd75, 16'd84, 16'd85, 16'd86
  };

  // parser shadow state
  rx_phase_e   rx_phase       = RxIdle;
  logic [15:0] pred_device_id = 16'd1;
  logic [7:0]  low_byte       = '0;
  logic [15:0] frm_id         = '0;
  logic [15:0] frm_cmd        = '0;
  logic [15:0] frm_len        = '0;
  logic [15:0] byte_cnt       = '0;
  logic [15:0] sum_acc        = '0;
  logic [15:0] sum_rcvd       = '0;
  logic [7:0]  prev_byte      = '0;
  logic [7:0]  pay_buf [cfr_pkg::MaxPayload];

  function automatic bit is_listed_command(input logic [15:0] c);
    bit hit;
    hit = 1'b0;
    foreach (listed_cmds[k]) begin
      if (listed_cmds[k] == c) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic int draw_gap();
    return idle_en ? int'($urandom_range(0, 10)) : 0;
  endfunction

  task automatic queue_result(input logic [7:0] d, input logic has, input logic lst,
                              input cfr_pkg::status_e st);
    rx_result_t r;
    r.data_byte = d;
    r.has_data  = has;
    r.is_last   = lst;
    r.status    = st;
    r.command   = frm_cmd;
    r.length    = frm_len;
    expected_results_q.push_back(r);
  endtask

  // error item; some errors send the parser hunting for cr lf
  task automatic reject_frame(input cfr_pkg::status_e st, input bit hunt);
    queue_result(8'h00, 1'b0, 1'b1, st);
    if (hunt) begin
      rx_phase  = RxHunt;
      prev_byte = '0;
    end else begin
      rx_phase = RxIdle;
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [15:0] word;
    int          n;
    word = {b, low_byte};
    case (rx_phase)
      RxHeader: begin
        if (!byte_cnt[0]) begin
          low_byte = b;
          byte_cnt++;
        end else if (byte_cnt == 16'd1) begin
          frm_id = word;
          byte_cnt++;
        end else if (byte_cnt == 16'd3) begin
          frm_cmd = word;
          byte_cnt++;
        end else begin
          // length word closes the header: id, then command, then size
          frm_len = word;
          if (frm_id != pred_device_id) begin
            reject_frame(cfr_pkg::StWrongId, 1'b0);
          end else if (!is_listed_command(frm_cmd)) begin
            reject_frame(cfr_pkg::StBadCmd, 1'b0);
          end else if (frm_len > 16'(cfr_pkg::MaxPayload)) begin
            reject_frame(cfr_pkg::StTooLong, 1'b1);
          end else begin
            sum_acc  = pred_device_id + frm_cmd + frm_len;
            byte_cnt = '0;
            rx_phase = (frm_len == 16'd0) ? RxSumLo : RxPayload;
          end
        end
      end
      RxPayload: begin
        if (byte_cnt < 16'(cfr_pkg::MaxPayload)) begin
          pay_buf[byte_cnt] = b;
        end
        sum_acc = sum_acc + {8'd0, b};
        byte_cnt++;
        if (byte_cnt >= frm_len) begin
          rx_phase = RxSumLo;
        end
      end
      RxSumLo: begin
        low_byte = b;
        rx_phase = RxSumHi;
      end
      RxSumHi: begin
        sum_rcvd = word;
        rx_phase = RxCr;
      end
      RxCr: begin
        prev_byte = b;
        rx_phase  = RxLf;
      end
      RxLf: begin
        if (!(prev_byte == cfr_pkg::CrByte && b == cfr_pkg::LfByte)) begin
          reject_frame(cfr_pkg::StBadTrailer, 1'b1);
        end else if (sum_rcvd != sum_acc) begin
          reject_frame(cfr_pkg::StChecksum, 1'b0);
        end else begin
          rx_phase = RxIdle;
          if (frm_len == 16'd0) begin
            queue_result(8'h00, 1'b0, 1'b1, cfr_pkg::StOk);
          end else begin
            for (n = 0; n < int'(frm_len); n++) begin
              queue_result(pay_buf[n], 1'b1, n + 1 == int'(frm_len), cfr_pkg::StOk);
            end
          end
        end
      end
      RxHunt: begin
        if (prev_byte == cfr_pkg::CrByte && b == cfr_pkg::LfByte) begin
          rx_phase  = RxIdle;
          prev_byte = '0;
        end else begin
          prev_byte = b;
        end
      end
      default: begin
        if (b == cfr_pkg::StartByte) begin
          rx_phase = RxHeader;
          byte_cnt = '0;
          low_byte = '0;
          frm_id   = '0;
          frm_cmd  = '0;
          frm_len  = '0;
          sum_acc  = '0;
          sum_rcvd = '0;
        end else begin
          frm_cmd = '0;
          frm_len = '0;
          reject_frame(cfr_pkg::StNoStart, 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_val, act_val);
      fail_count++;
    end
  endtask

  // byte driver: accepted bytes go through the predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata);
        bytes_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() > 0) begin
          s_axis_tdata  <= rx_bytes_q.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap = draw_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls and one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual data %0h user %0h last %0b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_results_q.pop_front();
          check_field("data_byte", 16'(want.data_byte), 16'(m_axis_tdata[7:0]));
          check_field("has_data", 16'(want.has_data), 16'(m_axis_tuser[0]));
          check_field("last", 16'(want.is_last), 16'(m_axis_tlast));
          check_field("status", 16'(want.status), 16'(m_axis_tuser[3:1]));
          check_field("command", want.command, m_axis_tdata[23:8]);
          check_field("length", want.length, m_axis_tdata[39:24]);
        end
        recv_wait = draw_gap();
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // stimulus helpers
  task automatic push_rx_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_word(input logic [15:0] w);
    push_rx_byte(w[7:0]);
    push_rx_byte(w[15:8]);
  endtask

  // a little noise, then cr lf to end the hunt
  task automatic push_resync();
    int k;
    for (k = 0; k < int'($urandom_range(0, 3)); k++) begin
      push_rx_byte(8'($urandom_range(0, 255)));
    end
    push_rx_byte(cfr_pkg::CrByte);
    push_rx_byte(cfr_pkg::LfByte);
  endtask

  task automatic push_frame(input logic [15:0] id, input logic [15:0] cmd,
                            input logic [15:0] len, input frame_fault_e fault);
    logic [15:0] sum;
    logic [7:0]  pb;
    logic [7:0]  tr_cr;
    logic [7:0]  tr_lf;
    int          i;
    push_rx_byte(cfr_pkg::StartByte);
    push_word(id);
    push_word(cmd);
    push_word(len);
    // header rejects leave the parser idle right away
    if (id != cfg_device_id || !is_listed_command(cmd)) begin
      return;
    end
    if (len > 16'(cfr_pkg::MaxPayload)) begin
      push_resync();
      return;
    end
    sum = cfg_device_id + cmd + len;
    for (i = 0; i < int'(len); i++) begin
      pb  = 8'($urandom_range(0, 255));
      sum = sum + {8'd0, pb};
      push_rx_byte(pb);
    end
    if (fault == FrBadSum) begin
      sum = sum ^ 16'($urandom_range(1, 65535));
    end
    push_word(sum);
    tr_cr = cfr_pkg::CrByte;
    tr_lf = cfr_pkg::LfByte;
    if (fault == FrBadCr) begin
      do tr_cr = 8'($urandom_range(0, 255)); while (tr_cr == cfr_pkg::CrByte);
    end
    if (fault == FrBadLf) begin
      do tr_lf = 8'($urandom_range(0, 255)); while (tr_lf == cfr_pkg::LfByte);
    end
    push_rx_byte(tr_cr);
    push_rx_byte(tr_lf);
    if (fault == FrBadCr || fault == FrBadLf) begin
      push_resync();
    end
  endtask

  function automatic logic [15:0] pick_listed_cmd();
    return listed_cmds[5'($urandom_range(0, 31))];
  endfunction

  function automatic logic [15:0] pick_unlisted_cmd();
    logic [15:0] c;
    do c = 16'($urandom_range(0, 65535)); while (is_listed_command(c));
    return c;
  endfunction

  // mostly short payloads, now and then up to the buffer size
  function automatic logic [15:0] pick_length();
    if ($urandom_range(0, 9) == 0) begin
      return 16'($urandom_range(9, cfr_pkg::MaxPayload));
    end
    return 16'($urandom_range(0, 8));
  endfunction

  task automatic push_random_sequence();
    int          r;
    int          k;
    logic [7:0]  b;
    r = int'($urandom_range(0, 99));
    if (r < 55) begin
      push_frame(cfg_device_id, pick_listed_cmd(), pick_length(), FrGood);
    end else if (r < 63) begin
      push_frame(cfg_device_id, pick_listed_cmd(), pick_length(), FrBadSum);
    end else if (r < 68) begin
      push_frame(cfg_device_id, pick_listed_cmd(), pick_length(), FrBadCr);
    end else if (r < 73) begin
      push_frame(cfg_device_id, pick_listed_cmd(), pick_length(), FrBadLf);
    end else if (r < 79) begin
      push_frame(cfg_device_id ^ 16'($urandom_range(1, 65535)), pick_listed_cmd(),
                 pick_length(), FrGood);
    end else if (r < 85) begin
      push_frame(cfg_device_id, pick_unlisted_cmd(), pick_length(), FrGood);
    end else if (r < 90) begin
      push_frame(cfg_device_id, pick_listed_cmd(),
                 16'($urandom_range(cfr_pkg::MaxPayload + 1, 65535)), FrGood);
    end else if (r < 95) begin
      do b = 8'($urandom_range(0, 255)); while (b == cfr_pkg::StartByte);
      push_rx_byte(b);
      push_resync();
    end else begin
      // frame cut short: following bytes get parsed as its continuation
      push_rx_byte(cfr_pkg::StartByte);
      for (k = 0; k < int'($urandom_range(1, 10)); k++) begin
        push_rx_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_accepted();
    while (bytes_accepted != bytes_queued) begin
      @(negedge clk_i);
    end
  endtask

  // everything in, every item out, then let a possible drain finish
  task automatic wait_quiet();
    while (bytes_accepted != bytes_queued || expected_results_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // steer the parser back to idle so the next register write is safe
  task automatic drain_to_idle();
    wait_accepted();
    while (rx_phase != RxIdle) begin
      if (rx_phase == RxHunt) begin
        push_rx_byte((prev_byte == cfr_pkg::CrByte) ? cfr_pkg::LfByte : cfr_pkg::CrByte);
      end else begin
        push_rx_byte(8'h00);
      end
      wait_accepted();
    end
    wait_quiet();
  endtask

  task automatic write_device_id(input logic [15:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    cfg_device_id  = v;
    pred_device_id = v;
    @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      push_random_sequence();
    end
    drain_to_idle();
  endtask

  // run ceiling
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset device id, limits and every error path
    push_frame(16'd1, 16'd0, 16'd0, FrGood);
    push_frame(16'd1, 16'd86, 16'd1, FrGood);
    push_frame(16'd1, 16'd44, 16'(cfr_pkg::MaxPayload), FrGood);
    push_frame(16'hFFFF, 16'd11, 16'd0, FrGood);
    push_frame(16'd1, 16'hFFFF, 16'd0, FrGood);
    push_frame(16'd1, 16'd8, 16'd2, FrGood);
    push_frame(16'd1, 16'd20, 16'(cfr_pkg::MaxPayload + 1), FrGood);
    push_frame(16'd1, 16'd60, 16'hFFFF, FrGood);
    push_frame(16'd1, 16'd68, 16'd3, FrBadSum);
    push_frame(16'd1, 16'd75, 16'd2, FrBadCr);
    push_frame(16'd1, 16'd0, 16'd0, FrBadLf);
    // no start byte, then a hunt that sees cr cr lf
    push_rx_byte(8'h00);
    push_rx_byte(8'hFF);
    push_rx_byte(cfr_pkg::CrByte);
    push_rx_byte(cfr_pkg::CrByte);
    push_rx_byte(cfr_pkg::LfByte);
    push_rx_byte(8'hFF);
    push_rx_byte(cfr_pkg::CrByte);
    push_rx_byte(cfr_pkg::LfByte);
    drain_to_idle();

    // all-ones id wraps the sum; long output hold-off fills the block
    write_device_id(16'hFFFF);
    hold_req++;
    repeat (2) push_frame(16'hFFFF, pick_listed_cmd(), 16'd16, FrGood);
    run_random_phase(15);

    // zero id, no idling on either side
    write_device_id(16'h0000);
    idle_en = 1'b0;
    push_frame(16'h0000, 16'd0, 16'd0, FrGood);
    run_random_phase(15);
    idle_en = 1'b1;

    write_device_id(16'($urandom_range(0, 65535)));
    run_random_phase(15);

    write_device_id(16'd1);
    run_random_phase(15);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_buf.sv
hw/rtl/cfr_parser.sv
hw/rtl/checksummed_frame_receiver.sv
bench/tb_top.sv
